### design/dln_pkg.sv
// ----------------------------------------------------------------------------
// dln_pkg
// Shared constants, codes and types of the dense layer neuron engine.
// ----------------------------------------------------------------------------
package dln_pkg;

  localparam int MAX_INPUTS  = 1024;
  localparam int MAX_OUTPUTS = 512;
  localparam int FRAC_BITS   = 12;

  // Field widths of the item and result beats
  localparam int DATA_W = 16;
  localparam int ROW_W  = 9;
  localparam int COL_W  = 10;
  localparam int REQ_W  = 2;

  // Configuration port
  localparam int CNT_W      = 11;
  localparam int MODE_W     = 2;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVATION_MODE = 1'd1;

  localparam logic [CNT_W-1:0]  CNT_RESET  = 11'd784;
  localparam logic [MODE_W-1:0] MODE_RESET = 2'd1;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_WR_WEIGHT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WR_BIAS   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_WR_INPUT  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_EVAL      = 2'd3;

  // Activation codes (the unused code behaves as none)
  localparam logic [MODE_W-1:0] ACT_NONE  = 2'd0;
  localparam logic [MODE_W-1:0] ACT_RELU  = 2'd1;
  localparam logic [MODE_W-1:0] ACT_LEAKY = 2'd2;

  // Leaky slope is 41 / 2^LEAK_SHIFT
  localparam int LEAK_SHIFT = 12;
  localparam int LEAK_GROW  = 6;

  // Storage address widths
  localparam int W_DEPTH = MAX_OUTPUTS * MAX_INPUTS;
  localparam int W_AW    = $clog2(W_DEPTH);
  localparam int X_AW    = $clog2(MAX_INPUTS);
  localparam int B_AW    = $clog2(MAX_OUTPUTS);
  localparam int IDX_W   = $clog2(MAX_INPUTS + 1);

  // Datapath widths
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_INPUTS) + 1;
  localparam int ACT_W  = ACC_W + LEAK_GROW;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
    logic bias_en;
  } mac_ctrl_t;

endpackage

### design/dln_req_if.sv
// ----------------------------------------------------------------------------
// dln_req_if
// Request channel: weight, bias and input writes and row evaluations.
// ----------------------------------------------------------------------------
interface dln_req_if
  import dln_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic        [REQ_W-1:0]  req_type;
  logic        [ROW_W-1:0]  row;
  logic        [COL_W-1:0]  col;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, req_type, row, col, value, input ready);
  modport sink   (input valid, req_type, row, col, value, output ready);
endinterface

### design/dln_rsp_if.sv
// ----------------------------------------------------------------------------
// dln_rsp_if
// Result channel: one beat per request.
// ----------------------------------------------------------------------------
interface dln_rsp_if
  import dln_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic                     evaluated;

  modport source (output valid, result_value, evaluated, input ready);
  modport sink   (input valid, result_value, evaluated, output ready);
endinterface

### design/dln_ram.sv
// ----------------------------------------------------------------------------
// dln_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dln_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/dln_mac.sv
// ----------------------------------------------------------------------------
// dln_mac
// Shared multiply-accumulate unit: one registered product and one wide add
// per cycle, plus the bias add at the end of a row.
// ----------------------------------------------------------------------------
module dln_mac
  import dln_pkg::*;
(
  input  logic                     clk,
  input  mac_ctrl_t                ctrl,
  input  logic signed [DATA_W-1:0] w_data,
  input  logic signed [DATA_W-1:0] x_data,
  input  logic signed [DATA_W-1:0] bias,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  bias_ext;

  assign prod_ext = ACC_W'(prod);
  // bias moves up by FRAC_BITS to line up with the Q8.24 products
  assign bias_ext = ACC_W'(bias) <<< FRAC_BITS;

  always_comb begin
    acc_next = acc;
    if (ctrl.clear) begin
      acc_next = '0;
    end else if (ctrl.acc_en) begin
      acc_next = acc + prod_ext;
    end else if (ctrl.bias_en) begin
      acc_next = acc + bias_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= w_data * x_data;
    end
    acc <= acc_next;
  end

endmodule

### design/dense_layer_neuron_eval_core.sv
// ----------------------------------------------------------------------------
// dense_layer_neuron_eval_core
// Fully connected layer neuron engine with none / ReLU / leaky ReLU output.
// ----------------------------------------------------------------------------
// Weight, bias and input writes answer with a zero beat. An evaluate walks
// the first min(input_count, 1024) entries of the row with one
// multiply-accumulate per cycle on the weight and input RAM read ports; the
// request side stays not ready from accept to result. Stores have no reset:
// read only entries that were written. Values are signed Q4.12; the sum is
// kept exact, then activated, floored to Q4.12 and saturated to 16 bits.
module dense_layer_neuron_eval_core
  import dln_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  dln_req_if.sink               req,
  dln_rsp_if.source             rsp
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_BIAS = 3'd2;
  localparam logic [2:0] S_ACT  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam logic signed [ACT_W-1:0] SAT_HI = ACT_W'(2 ** (DATA_W - 1) - 1);
  localparam logic signed [ACT_W-1:0] SAT_LO = -SAT_HI - ACT_W'(1);

  logic [2:0]        state;
  logic [CNT_W-1:0]  input_count;
  logic [MODE_W-1:0] activation_mode;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  n_len;
  logic [W_AW-1:0]   base;
  logic              v1;
  logic              v2;

  logic                     out_valid;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_eval;

  logic signed [ACT_W-1:0]  act;
  logic signed [ACT_W-1:0]  act_next;
  logic signed [ACT_W-1:0]  acc_wide;
  logic signed [ACT_W-1:0]  leak_prod;
  logic signed [ACT_W-1:0]  shifted;
  logic signed [DATA_W-1:0] sat_value;

  logic accept;
  logic out_free;
  logic out_load;
  logic row_ok;
  logic col_ok;
  logic issue;
  logic mac_done;
  logic [IDX_W-1:0] n_clip;

  logic [W_AW-1:0] w_waddr;
  logic [W_AW-1:0] w_raddr;
  logic signed [DATA_W-1:0] w_rdata;
  logic signed [DATA_W-1:0] x_rdata;
  logic signed [DATA_W-1:0] b_rdata;
  logic signed [ACC_W-1:0]  acc;
  mac_ctrl_t                mac_ctrl;

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;

  assign row_ok = 32'(req.row) < MAX_OUTPUTS;
  assign col_ok = 32'(req.col) < MAX_INPUTS;
  assign n_clip = (32'(input_count) > MAX_INPUTS) ? IDX_W'(MAX_INPUTS) : IDX_W'(input_count);

  // load the output register with a write answer or a finished row
  assign out_load = (accept && !((req.req_type == REQ_EVAL) && row_ok)) ||
                    ((state == S_OUT) && out_free);

  assign issue    = (state == S_MAC) && (idx < n_len);
  assign mac_done = (state == S_MAC) && (idx == n_len) && !v1 && !v2;

  assign w_waddr = W_AW'(W_AW'(req.row) * W_AW'(MAX_INPUTS) + W_AW'(req.col));
  assign w_raddr = base + W_AW'(idx);

  dln_ram #(.WIDTH(DATA_W), .DEPTH(W_DEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (accept && (req.req_type == REQ_WR_WEIGHT) && row_ok && col_ok),
    .waddr (w_waddr),
    .wdata (req.value),
    .re    (issue),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  dln_ram #(.WIDTH(DATA_W), .DEPTH(MAX_INPUTS)) u_input_ram (
    .clk   (clk),
    .we    (accept && (req.req_type == REQ_WR_INPUT) && col_ok),
    .waddr (req.col[X_AW-1:0]),
    .wdata (req.value),
    .re    (issue),
    .raddr (idx[X_AW-1:0]),
    .rdata (x_rdata)
  );

  // bias is read once at accept and held in the read register for the row
  dln_ram #(.WIDTH(DATA_W), .DEPTH(MAX_OUTPUTS)) u_bias_ram (
    .clk   (clk),
    .we    (accept && (req.req_type == REQ_WR_BIAS) && row_ok),
    .waddr (req.row[B_AW-1:0]),
    .wdata (req.value),
    .re    (accept && (req.req_type == REQ_EVAL)),
    .raddr (req.row[B_AW-1:0]),
    .rdata (b_rdata)
  );

  always_comb begin
    mac_ctrl.clear   = accept;
    mac_ctrl.mul_en  = v1;
    mac_ctrl.acc_en  = v2;
    mac_ctrl.bias_en = (state == S_BIAS);
  end

  dln_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .w_data (w_rdata),
    .x_data (x_rdata),
    .bias   (b_rdata),
    .acc    (acc)
  );

  // activation: leaky slope is x41 as shift-add, then floor by LEAK_SHIFT
  assign acc_wide  = ACT_W'(acc);
  assign leak_prod = (acc_wide <<< 5) + (acc_wide <<< 3) + acc_wide;

  always_comb begin
    case (activation_mode)
      ACT_RELU: begin
        act_next = (acc < 0) ? '0 : acc_wide;
      end
      ACT_LEAKY: begin
        act_next = (acc <= 0) ? (leak_prod >>> LEAK_SHIFT) : acc_wide;
      end
      default: begin
        act_next = acc_wide;
      end
    endcase
  end

  assign shifted = act >>> FRAC_BITS;

  always_comb begin
    if (shifted > SAT_HI) begin
      sat_value = SAT_HI[DATA_W-1:0];
    end else if (shifted < SAT_LO) begin
      sat_value = SAT_LO[DATA_W-1:0];
    end else begin
      sat_value = shifted[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      input_count     <= CNT_RESET;
      activation_mode <= MODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INPUT_COUNT:     input_count     <= cfg_data[CNT_W-1:0];
        REG_ACTIVATION_MODE: activation_mode <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.req_type == REQ_EVAL && row_ok) begin
              state <= S_MAC;
              idx   <= '0;
              n_len <= n_clip;
              base  <= W_AW'(W_AW'(req.row) * W_AW'(MAX_INPUTS));
            end else begin
              // writes and out-of-range rows answer with a zero beat
              out_value <= '0;
              out_eval  <= 1'b0;
            end
          end
        end
        S_MAC: begin
          if (issue) begin
            idx <= idx + IDX_W'(1);
          end
          if (mac_done) begin
            state <= S_BIAS;
          end
        end
        S_BIAS: begin
          state <= S_ACT;
        end
        S_ACT: begin
          act   <= act_next;
          state <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_free) begin
            out_value <= sat_value;
            out_eval  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.result_value = out_value;
  assign rsp.evaluated    = out_eval;

endmodule

### design/dln_checker.sv
// ----------------------------------------------------------------------------
// dln_checker
// Port-level checks of the neuron engine, bound to the top level.
// ----------------------------------------------------------------------------
module dln_checker
  import dln_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [REQ_W-1:0]         in_req_type,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_value,
  input logic                     out_evaluated
);

  // a result beat that stalls keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_evaluated))
    else $error("result beat changed while stalled");

  // a beat that is not an evaluate answer carries zero
  a_zero_plain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_evaluated |-> out_value == '0)
    else $error("non-evaluate beat with nonzero value");

  // a write answers on the next cycle
  a_write_answer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_req_type != REQ_EVAL |=> out_valid && !out_evaluated)
    else $error("write beat without its answer");

  // an evaluate keeps the request side busy
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_req_type == REQ_EVAL |=> !in_ready)
    else $error("request taken during an evaluate");

  // reset drops any pending result
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind dense_layer_neuron_eval_core dln_checker u_dln_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (req.valid),
  .in_ready      (req.ready),
  .in_req_type   (req.req_type),
  .out_valid     (rsp.valid),
  .out_ready     (rsp.ready),
  .out_value     (rsp.result_value),
  .out_evaluated (rsp.evaluated)
);

### bench/dln_eval_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dln_eval_checker
// Watches the configuration port and both channels of the neuron engine,
// keeps its own copy of the weight, bias and input stores, predicts one
// result beat per accepted request and compares each result beat in order.
// ----------------------------------------------------------------------------
module dln_eval_checker
  import dln_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  dln_req_if                    req_ch,
  dln_rsp_if                    rsp_ch,
  output int                    fail_count,
  output int                    outstanding,
  output int                    evals_checked
);

  localparam longint LEAK_MUL = 41;
  localparam longint Q_MAX    = 32767;
  localparam longint Q_MIN    = -32768;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     evaluated;
  } rsp_beat_t;

  bit signed [DATA_W-1:0] wt_mem   [W_DEPTH];
  bit signed [DATA_W-1:0] bias_mem [MAX_OUTPUTS];
  bit signed [DATA_W-1:0] in_vec   [MAX_INPUTS];

  int                dot_len = int'(CNT_RESET);
  logic [MODE_W-1:0] act_sel = MODE_RESET;

  rsp_beat_t expected_beats [$];
  rsp_beat_t exp_beat;
  int        errs  = 0;
  int        evals = 0;

  // Apply one request to the local stores and return the beat it must cause.
  function automatic rsp_beat_t neuron_beat(input logic [REQ_W-1:0]         kind,
                                            input logic [ROW_W-1:0]         r,
                                            input logic [COL_W-1:0]         c,
                                            input logic signed [DATA_W-1:0] v);
    rsp_beat_t beat;
    longint    acc;
    int        n;
    int        j;
    int        base;
    beat.result_value = '0;
    beat.evaluated    = 1'b0;
    base = int'(r) * MAX_INPUTS;
    case (kind)
      REQ_WR_WEIGHT: wt_mem[base + int'(c)] = v;
      REQ_WR_BIAS:   bias_mem[r] = v;
      REQ_WR_INPUT:  in_vec[c] = v;
      default: begin
        n = (dot_len > MAX_INPUTS) ? MAX_INPUTS : dot_len;
        acc = 0;
        for (j = 0; j < n; j++)
          acc += longint'(wt_mem[base + j]) * longint'(in_vec[j]);
        acc += longint'(bias_mem[r]) * (longint'(1) << FRAC_BITS);
        // the unused mode code falls through as no activation
        case (act_sel)
          ACT_RELU:  if (acc < 0) acc = 0;
          ACT_LEAKY: if (acc <= 0) acc = (acc * LEAK_MUL) >>> LEAK_SHIFT;
          default: ;
        endcase
        acc = acc >>> FRAC_BITS;
        if (acc > Q_MAX) acc = Q_MAX;
        else if (acc < Q_MIN) acc = Q_MIN;
        beat.result_value = acc[DATA_W-1:0];
        beat.evaluated    = 1'b1;
      end
    endcase
    return beat;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      dot_len = int'(CNT_RESET);
      act_sel = MODE_RESET;
      expected_beats.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_INPUT_COUNT) dot_len = int'(cfg_data[CNT_W-1:0]);
        else if (cfg_index == REG_ACTIVATION_MODE) act_sel = cfg_data[MODE_W-1:0];
      end
      // push before pop so a same-cycle answer still finds its entry
      if (req_ch.valid && req_ch.ready)
        expected_beats.push_back(neuron_beat(req_ch.req_type, req_ch.row, req_ch.col,
                                             req_ch.value));
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_beats.size() == 0) begin
          errs++;
          $error("result beat with no request waiting: result_value %0d evaluated %0b",
                 $signed(rsp_ch.result_value), rsp_ch.evaluated);
        end else begin
          exp_beat = expected_beats.pop_front();
          if (rsp_ch.result_value !== exp_beat.result_value) begin
            errs++;
            $error("result_value: expected %0d, got %0d",
                   $signed(exp_beat.result_value), $signed(rsp_ch.result_value));
          end
          if (rsp_ch.evaluated !== exp_beat.evaluated) begin
            errs++;
            $error("evaluated: expected %0b, got %0b", exp_beat.evaluated, rsp_ch.evaluated);
          end
          if (exp_beat.evaluated) evals++;
        end
      end
    end
    outstanding   <= expected_beats.size();
    fail_count    <= errs;
    evals_checked <= evals;
  end

endmodule

### bench/tb_dense_layer_neuron_eval_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dense_layer_neuron_eval_core
// Drives the neuron engine with directed corner requests and a series of
// random phases under changing dot lengths and activation modes, with
// random gaps and back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_dense_layer_neuron_eval_core
  import dln_pkg::*;
();

  localparam int STALL_LIMIT   = 20000;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_WAIT    = 64;
  localparam int NUM_PHASES    = 12;
  localparam int PHASE_ITEMS   = 63;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dln_req_if req_ch ();
  dln_rsp_if rsp_ch ();

  int fail_count;
  int outstanding;
  int evals_checked;

  dense_layer_neuron_eval_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  dln_eval_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_ch        (req_ch),
    .rsp_ch        (rsp_ch),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .evals_checked (evals_checked)
  );

  // Which entries have been written, so no evaluate reads an unwritten one
  bit w_loaded [W_DEPTH];
  bit b_loaded [MAX_OUTPUTS];
  bit x_loaded [MAX_INPUTS];
  int loaded_rows [$];

  int                cur_len  = int'(CNT_RESET);
  logic [MODE_W-1:0] cur_mode = MODE_RESET;
  int                longest_len = 0;
  int                items_sent  = 0;
  int                reg_writes  = 0;
  int                stuck       = 0;
  bit                calm        = 1'b0;
  bit                stall_request = 1'b0;

  logic [REQ_W-1:0] write_kinds [3] = '{REQ_WR_WEIGHT, REQ_WR_BIAS, REQ_WR_INPUT};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (calm) return 0;
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return DATA_W'($urandom_range(0, 8191) - 4096);
    if (pick < 8) return DATA_W'($urandom);
    case ($urandom_range(0, 4))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  function automatic int eff_len();
    return (cur_len > MAX_INPUTS) ? MAX_INPUTS : cur_len;
  endfunction

  function automatic bit row_ready(input int r);
    int j;
    if (!b_loaded[r]) return 1'b0;
    for (j = 0; j < eff_len(); j++)
      if (!w_loaded[r * MAX_INPUTS + j] || !x_loaded[j]) return 1'b0;
    return 1'b1;
  endfunction

  // Response side: random ready with an occasional long hold-off
  initial begin
    int run;
    int gap;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stall_request) begin
        stall_request = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      run = $urandom_range(1, 24);
      rsp_ch.ready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
      if (stuck >= STALL_LIMIT) begin
        $display("dense_layer_neuron_eval_core: mismatch");
        $finish;
      end
    end
  end

  task automatic send_req(input logic [REQ_W-1:0] kind, input int r, input int c,
                          input logic [DATA_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.row      <= r[ROW_W-1:0];
    req_ch.col      <= c[COL_W-1:0];
    req_ch.value    <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    case (kind)
      REQ_WR_WEIGHT: w_loaded[(r % MAX_OUTPUTS) * MAX_INPUTS + (c % MAX_INPUTS)] = 1'b1;
      REQ_WR_BIAS:   b_loaded[r % MAX_OUTPUTS] = 1'b1;
      REQ_WR_INPUT:  x_loaded[c % MAX_INPUTS] = 1'b1;
      default: ;
    endcase
    items_sent++;
  endtask

  task automatic send_eval(input int r);
    send_req(REQ_EVAL, r, $urandom_range(0, MAX_INPUTS - 1), DATA_W'($urandom));
  endtask

  // Drop valid and hold until every result beat is back
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input int len, input logic [MODE_W-1:0] mode, input bit junk);
    logic [CFG_DATA_W-1:0] mode_word;
    mode_word = junk ? CFG_DATA_W'($urandom) : '0;
    mode_word[MODE_W-1:0] = mode;
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_INPUT_COUNT;
    cfg_data  <= len[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= REG_ACTIVATION_MODE;
    cfg_data  <= mode_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_len  = len;
    cur_mode = mode;
    reg_writes += 2;
    if (len > longest_len) longest_len = len;
  endtask

  task automatic fill_inputs();
    int j;
    for (j = 0; j < eff_len(); j++)
      if (!x_loaded[j]) send_req(REQ_WR_INPUT, $urandom_range(0, MAX_OUTPUTS - 1), j,
                                 rand_value());
  endtask

  // Well-formed row load; without the evaluate it is a broken sequence
  task automatic load_row(input int r, input int upto, input bit do_eval);
    int c;
    if (!b_loaded[r] || $urandom_range(0, 3) == 0)
      send_req(REQ_WR_BIAS, r, $urandom_range(0, MAX_INPUTS - 1), rand_value());
    for (c = 0; c < upto; c++) begin
      if (!w_loaded[r * MAX_INPUTS + c] || $urandom_range(0, 2) == 0)
        send_req(REQ_WR_WEIGHT, r, c, rand_value());
      if ($urandom_range(0, 15) == 0)
        send_req(REQ_WR_INPUT, $urandom_range(0, MAX_OUTPUTS - 1),
                 $urandom_range(0, MAX_INPUTS - 1), rand_value());
    end
    if (do_eval && row_ready(r)) begin
      send_eval(r);
      loaded_rows.push_back(r);
    end
  endtask

  task automatic reeval_row();
    int r;
    if (loaded_rows.size() == 0) return;
    r = loaded_rows[$urandom_range(0, loaded_rows.size() - 1)];
    if (row_ready(r)) send_eval(r);
  endtask

  task automatic noise_write();
    send_req(write_kinds[$urandom_range(0, 2)], $urandom_range(0, MAX_OUTPUTS - 1),
             $urandom_range(0, MAX_INPUTS - 1), rand_value());
  endtask

  task automatic directed_items();
    // bias alone with an empty dot product, both extremes
    set_config(0, ACT_NONE, 1'b0);
    send_req(REQ_WR_BIAS, 0, 0, 16'h7FFF);
    send_req(REQ_WR_BIAS, MAX_OUTPUTS - 1, MAX_INPUTS - 1, 16'h8000);
    send_eval(0);
    send_eval(MAX_OUTPUTS - 1);
    set_config(2, ACT_NONE, 1'b0);
    send_req(REQ_WR_INPUT, 0, 0, 16'h7FFF);
    send_req(REQ_WR_INPUT, 0, 1, 16'h8000);
    send_req(REQ_WR_INPUT, MAX_OUTPUTS - 1, MAX_INPUTS - 1, 16'hFFFF);
    send_req(REQ_WR_WEIGHT, 0, 0, 16'h7FFF);
    send_req(REQ_WR_WEIGHT, 0, 1, 16'h8000);
    send_req(REQ_WR_WEIGHT, MAX_OUTPUTS - 1, 0, 16'h8000);
    send_req(REQ_WR_WEIGHT, MAX_OUTPUTS - 1, 1, 16'h8000);
    send_req(REQ_WR_WEIGHT, MAX_OUTPUTS - 1, MAX_INPUTS - 1, 16'h0001);
    send_req(REQ_WR_BIAS, 1, 0, 16'h8000);
    send_req(REQ_WR_WEIGHT, 1, 0, 16'h8000);
    send_req(REQ_WR_WEIGHT, 1, 1, 16'h7FFF);
    send_req(REQ_WR_BIAS, 2, 0, 16'h0000);
    send_req(REQ_WR_WEIGHT, 2, 0, 16'h0000);
    send_req(REQ_WR_WEIGHT, 2, 1, 16'h0000);
    send_eval(0);
    send_eval(1);
    send_eval(MAX_OUTPUTS - 1);
    set_config(2, ACT_RELU, 1'b0);
    send_eval(MAX_OUTPUTS - 1);
    send_eval(0);
    set_config(2, ACT_LEAKY, 1'b0);
    send_eval(MAX_OUTPUTS - 1);
    send_eval(1);
    send_eval(2);
    set_config(2, 2'd3, 1'b0);
    send_eval(1);
    loaded_rows.push_back(0);
    loaded_rows.push_back(1);
    loaded_rows.push_back(2);
    loaded_rows.push_back(MAX_OUTPUTS - 1);
  endtask

  task automatic random_phase(input int p);
    int len;
    int pick;
    int start;
    logic [MODE_W-1:0] mode;
    pick = $urandom_range(0, 9);
    if (p == 0) len = 1;
    else if (p == 1) len = 0;
    else if (pick < 7) len = $urandom_range(1, 12);
    else if (pick < 9) len = $urandom_range(13, 40);
    else len = $urandom_range(41, 100);
    mode = (p < 4) ? MODE_W'(p) : MODE_W'($urandom_range(0, 3));
    set_config(len, mode, 1'($urandom_range(0, 1)));
    fill_inputs();
    calm = (p == 5);
    if (p == 3 || p == 8) stall_request = 1'b1;
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) load_row($urandom_range(0, MAX_OUTPUTS - 1), eff_len(), 1'b1);
      else if (pick < 70) reeval_row();
      else if (pick < 80) load_row($urandom_range(0, MAX_OUTPUTS - 1),
                                   $urandom_range(0, eff_len()), 1'b0);
      else noise_write();
    end
    calm = 1'b0;
  endtask

  initial begin
    int p;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_INPUT_COUNT;
    cfg_data        <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_WR_WEIGHT;
    req_ch.row      <= '0;
    req_ch.col      <= '0;
    req_ch.value    <= '0;
    @(negedge rst);
    @(posedge clk);
    directed_items();
    for (p = 0; p < NUM_PHASES; p++) random_phase(p);
    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Sent %0d request beats, %0d row evaluations checked, over %0d register writes",
             items_sent, evals_checked, reg_writes);
    $display("Dot lengths 0 to %0d, all four activation codes, gaps and long output hold-offs",
             longest_len);
    if (fail_count == 0) $display("dense_layer_neuron_eval_core: match");
    else $display("dense_layer_neuron_eval_core: mismatch");
    $finish;
  end

endmodule
